// ----- rtl/mmrs_pkg.sv -----
// Package for the min-max route split block: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
package mmrs_pkg;

    localparam int MAX_CITIES = 31;
    localparam int MAX_ROUTES = 8;
    localparam int DIST_BITS  = 16;

    localparam int POS_W    = 5;
    localparam int K_W      = 4;
    localparam int R_W      = 3;
    localparam int LEN_W    = 21;
    localparam int DADDR_W  = 2 * POS_W;
    localparam int BADDR_W  = K_W + POS_W;

    localparam logic [1:0] FUNC_LOAD_DIST = 2'd0;
    localparam logic [1:0] FUNC_LOAD_TOUR = 2'd1;
    localparam logic [1:0] FUNC_RUN       = 2'd2;
    localparam logic [1:0] FUNC_NOP       = 2'd3;

    // Precompute phases: depot->city, city->depot, previous city->city
    localparam logic [1:0] PH_OUT  = 2'd0;
    localparam logic [1:0] PH_IN   = 2'd1;
    localparam logic [1:0] PH_EDGE = 2'd2;

    typedef struct packed {
        logic             load_dist;
        logic             load_tour;
        logic             pre_rd;
        logic [1:0]       ph;
        logic [POS_W-1:0] x;
        logic             dp_init;
        logic             dp_cmp;
        logic             dp_use;
        logic             dp_first;
        logic             dp_wr;
        logic             cap_max;
        logic             tb_rd;
        logic [POS_W-1:0] i;
        logic [POS_W-1:0] j;
        logic [K_W-1:0]   k;
        logic             emit;
        logic             emit_inf;
        logic             emit_last;
        logic [R_W-1:0]   r;
        logic [POS_W-1:0] p;
    } cmd_t;

    typedef struct packed {
        logic             out_free;
        logic [POS_W-1:0] cut;
    } stat_t;

endpackage

// ----- rtl/mmrs_if.sv -----
// Channel interfaces for the min-max route split block.
// Depends on nothing; widths follow the item fields.
interface mmrs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [15:0] value;
    modport source (output valid, func, row, col, value, input ready);
    modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface mmrs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  route;
    logic [4:0]  city;
    logic [20:0] max_length;
    logic        infeasible;
    logic        last;
    modport source (output valid, route, city, max_length, infeasible, last, input ready);
    modport sink   (input valid, route, city, max_length, infeasible, last, output ready);
endinterface

// ----- rtl/mmrs_datapath.sv -----
// Datapath: distance and tour stores, edge precompute, DP compare unit,
// best-value/cut memories and the output register. Uses mmrs_pkg.
module mmrs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mmrs_pkg::cmd_t                  cmd,
    output mmrs_pkg::stat_t                 stat,
    input  logic [4:0]                      ld_row,
    input  logic [4:0]                      ld_col,
    input  logic [15:0]                     ld_value,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [2:0]                      out_route,
    output logic [4:0]                      out_city,
    output logic [20:0]                     out_max_length,
    output logic                            out_infeasible,
    output logic                            out_last
);
    import mmrs_pkg::*;

    logic [DIST_BITS-1:0] dist_mem [0:(1<<DADDR_W)-1];
    logic [POS_W-1:0]     tour_mem [0:MAX_CITIES-1];
    logic [DIST_BITS-1:0] out_arr  [0:MAX_CITIES-1];
    logic [DIST_BITS-1:0] in_arr   [0:MAX_CITIES-1];
    logic [DIST_BITS-1:0] e_arr    [0:MAX_CITIES-1];
    logic [LEN_W-1:0]     bv_mem   [0:(1<<BADDR_W)-1];
    logic [POS_W-1:0]     cut_mem  [0:(1<<BADDR_W)-1];

    logic [DIST_BITS-1:0] d_rd_reg;
    logic [DADDR_W-1:0]   d_raddr;
    logic [POS_W-1:0]     tour_idx;
    logic [POS_W-1:0]     cur_city;
    logic [POS_W-1:0]     prev_reg;
    logic                 pre_v_reg;
    logic [POS_W-1:0]     pre_x_reg;
    logic [1:0]           pre_ph_reg;
    logic [BADDR_W-1:0]   b_raddr;
    logic [BADDR_W-1:0]   b_waddr;
    logic [LEN_W-1:0]     bv_rd_reg;
    logic [POS_W-1:0]     cut_rd_reg;
    logic [LEN_W-1:0]     pin_reg;
    logic [LEN_W-1:0]     best_m_reg;
    logic [POS_W-1:0]     best_j_reg;
    logic                 best_v_reg;
    logic [LEN_W-1:0]     max_reg;
    logic [LEN_W-1:0]     c_len;
    logic [LEN_W-1:0]     m_len;
    logic [K_W-1:0]       k_prev;
    logic                 out_v_reg;
    logic [2:0]           route_reg;
    logic [4:0]           city_reg;
    logic [20:0]          maxl_reg;
    logic                 inf_reg;
    logic                 last_reg;

    // Select addresses
    assign tour_idx = cmd.emit ? cmd.p : cmd.x;
    assign cur_city = tour_mem[tour_idx];
    assign k_prev   = cmd.k - K_W'(1);
    assign b_raddr  = cmd.tb_rd ? {cmd.k, cmd.i} : {k_prev, cmd.j};
    assign b_waddr  = {cmd.k, cmd.i};

    always_comb
    begin
        case (cmd.ph)
            PH_OUT:  d_raddr = {POS_W'(0), cur_city};
            PH_IN:   d_raddr = {cur_city, POS_W'(0)};
            default: d_raddr = {prev_reg, cur_city};
        endcase
    end

    // Distance memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_dist)
        begin
            dist_mem[{ld_row, ld_col}] <= ld_value;
        end
        d_rd_reg <= dist_mem[d_raddr];
    end

    // Tour store and per-position edge arrays
    always_ff @(posedge clk)
    begin
        if (cmd.load_tour && (32'(ld_row) < MAX_CITIES))
        begin
            tour_mem[ld_row] <= ld_value[POS_W-1:0];
        end
        if (cmd.pre_rd && (cmd.ph == PH_EDGE))
        begin
            prev_reg <= cur_city;
        end
        pre_x_reg  <= cmd.x;
        pre_ph_reg <= cmd.ph;
        if (pre_v_reg)
        begin
            case (pre_ph_reg)
                PH_OUT:  out_arr[pre_x_reg] <= d_rd_reg;
                PH_IN:   in_arr[pre_x_reg]  <= d_rd_reg;
                default: e_arr[pre_x_reg]   <= d_rd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= 1'b0;
        end
        else
        begin
            pre_v_reg <= cmd.pre_rd;
        end
    end

    // Candidate route length and running max
    assign c_len = LEN_W'(out_arr[cmd.j]) + pin_reg;
    assign m_len = (cmd.dp_first || (c_len >= bv_rd_reg)) ? c_len : bv_rd_reg;

    // DP step: keep the earliest cut on ties (j walks downward)
    always_ff @(posedge clk)
    begin
        bv_rd_reg  <= bv_mem[b_raddr];
        cut_rd_reg <= cut_mem[b_raddr];
        if (cmd.dp_init)
        begin
            pin_reg    <= LEN_W'(in_arr[cmd.i - POS_W'(1)]);
            best_v_reg <= 1'b0;
        end
        else if (cmd.dp_cmp)
        begin
            pin_reg <= pin_reg + LEN_W'(e_arr[cmd.j]);
            if (cmd.dp_use && (!best_v_reg || (m_len <= best_m_reg)))
            begin
                best_m_reg <= m_len;
                best_j_reg <= cmd.j;
                best_v_reg <= 1'b1;
            end
        end
        if (cmd.dp_wr)
        begin
            bv_mem[b_waddr]  <= best_m_reg;
            cut_mem[b_waddr] <= best_j_reg;
            if (cmd.cap_max)
            begin
                max_reg <= best_m_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_inf)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_inf)
        begin
            route_reg <= '0;
            city_reg  <= '0;
            maxl_reg  <= '0;
            inf_reg   <= 1'b1;
            last_reg  <= 1'b1;
        end
        else if (cmd.emit)
        begin
            route_reg <= cmd.r;
            city_reg  <= cur_city;
            maxl_reg  <= cmd.emit_last ? max_reg : '0;
            inf_reg   <= 1'b0;
            last_reg  <= cmd.emit_last;
        end
    end

    assign stat.out_free  = !out_v_reg || out_ready;
    assign stat.cut       = cut_rd_reg;
    assign out_valid      = out_v_reg;
    assign out_route      = route_reg;
    assign out_city       = city_reg;
    assign out_max_length = maxl_reg;
    assign out_infeasible = inf_reg;
    assign out_last       = last_reg;

endmodule

// ----- rtl/mmrs_ctrl.sv -----
// Controller: configuration registers, run sequencer and loop counters.
// Drives mmrs_datapath through cmd_t; uses mmrs_pkg.
module mmrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [4:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_func,
    input  mmrs_pkg::stat_t     stat,
    output mmrs_pkg::cmd_t      cmd
);
    import mmrs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRE   = 4'd1;
    localparam logic [3:0] S_PREW  = 4'd2;
    localparam logic [3:0] S_DPI   = 4'd3;
    localparam logic [3:0] S_DPRD  = 4'd4;
    localparam logic [3:0] S_DPCMP = 4'd5;
    localparam logic [3:0] S_DPWR  = 4'd6;
    localparam logic [3:0] S_TBRD  = 4'd7;
    localparam logic [3:0] S_TBCAP = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;
    localparam logic [3:0] S_INF   = 4'd10;

    localparam logic CFG_ROUTES = 1'b0;

    logic [3:0]       state_reg, state_next;
    logic [K_W-1:0]   kcfg_reg;
    logic [POS_W-1:0] ncfg_reg;
    logic [POS_W-1:0] x_reg, x_next;
    logic [1:0]       ph_reg, ph_next;
    logic [POS_W-1:0] i_reg, i_next;
    logic [POS_W-1:0] j_reg, j_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [R_W-1:0]   r_reg, r_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [POS_W-1:0] start_reg [0:MAX_ROUTES-1];
    logic             accept;
    logic             first_lvl;
    logic [POS_W-1:0] j_lo;
    logic             is_last;
    logic [POS_W-1:0] bound;
    logic [K_W-1:0]   r_inc;
    logic             infeas;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign first_lvl = (k_reg == K_W'(1));
    assign j_lo      = first_lvl ? '0 : POS_W'(k_reg - K_W'(1));
    assign is_last   = (p_reg == ncfg_reg - POS_W'(1));
    assign r_inc     = K_W'(r_reg) + K_W'(1);
    assign bound     = (r_inc == kcfg_reg) ? ncfg_reg : start_reg[R_W'(r_inc)];
    assign infeas    = (kcfg_reg == '0) || (32'(kcfg_reg) > MAX_ROUTES)
                       || (POS_W'(kcfg_reg) > ncfg_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcfg_reg <= K_W'(1);
            ncfg_reg <= POS_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROUTES)
            begin
                kcfg_reg <= cfg_wdata[K_W-1:0];
            end
            else
            begin
                ncfg_reg <= cfg_wdata;
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        ph_next    = ph_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        p_next     = p_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_func == FUNC_RUN))
                begin
                    x_next     = '0;
                    ph_next    = PH_OUT;
                    state_next = infeas ? S_INF : S_PRE;
                end
            end
            S_PRE:
            begin
                if (ph_reg == PH_EDGE)
                begin
                    ph_next = PH_OUT;
                    x_next  = x_reg + POS_W'(1);
                    if (x_reg == ncfg_reg - POS_W'(1))
                    begin
                        state_next = S_PREW;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            S_PREW:
            begin
                k_next     = K_W'(1);
                i_next     = POS_W'(1);
                state_next = S_DPI;
            end
            S_DPI:
            begin
                j_next     = i_reg - POS_W'(1);
                state_next = S_DPRD;
            end
            S_DPRD:
            begin
                state_next = S_DPCMP;
            end
            S_DPCMP:
            begin
                if (j_reg == j_lo)
                begin
                    state_next = S_DPWR;
                end
                else
                begin
                    j_next     = j_reg - POS_W'(1);
                    state_next = S_DPRD;
                end
            end
            S_DPWR:
            begin
                if (i_reg == ncfg_reg)
                begin
                    if (k_reg == kcfg_reg)
                    begin
                        state_next = S_TBRD;
                    end
                    else
                    begin
                        k_next     = k_reg + K_W'(1);
                        i_next     = POS_W'(k_reg + K_W'(1));
                        state_next = S_DPI;
                    end
                end
                else
                begin
                    i_next     = i_reg + POS_W'(1);
                    state_next = S_DPI;
                end
            end
            S_TBRD:
            begin
                state_next = S_TBCAP;
            end
            S_TBCAP:
            begin
                i_next = stat.cut;
                if (first_lvl)
                begin
                    r_next     = '0;
                    p_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    k_next     = k_reg - K_W'(1);
                    state_next = S_TBRD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next = p_reg + POS_W'(1);
                        if (p_reg + POS_W'(1) == bound)
                        begin
                            r_next = r_reg + R_W'(1);
                        end
                    end
                end
            end
            S_INF:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg     <= '0;
            ph_reg    <= PH_OUT;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            ph_reg    <= ph_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            p_reg     <= p_next;
        end
    end

    // Route start positions from the traceback
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TBCAP)
        begin
            start_reg[R_W'(k_reg - K_W'(1))] <= stat.cut;
        end
    end

    // Commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.load_dist = accept && (in_func == FUNC_LOAD_DIST);
        cmd.load_tour = accept && (in_func == FUNC_LOAD_TOUR);
        cmd.pre_rd    = (state_reg == S_PRE);
        cmd.ph        = ph_reg;
        cmd.x         = x_reg;
        cmd.dp_init   = (state_reg == S_DPI);
        cmd.dp_cmp    = (state_reg == S_DPCMP);
        cmd.dp_use    = !first_lvl || (j_reg == '0);
        cmd.dp_first  = first_lvl;
        cmd.dp_wr     = (state_reg == S_DPWR);
        cmd.cap_max   = (i_reg == ncfg_reg);
        cmd.tb_rd     = (state_reg == S_TBRD);
        cmd.i         = i_reg;
        cmd.j         = j_reg;
        cmd.k         = k_reg;
        cmd.emit      = (state_reg == S_EMIT) && stat.out_free;
        cmd.emit_inf  = (state_reg == S_INF) && stat.out_free;
        cmd.emit_last = is_last;
        cmd.r         = r_reg;
        cmd.p         = p_reg;
    end

endmodule

// ----- rtl/minmax_route_split_dp.sv -----
// Top level of the min-max route split block: joins controller and datapath.
// Depends on mmrs_pkg, mmrs_if, mmrs_ctrl and mmrs_datapath.
//
//  channel  | dir | transaction
//  ---------+-----+-------------------------------------------------
//  in_ch    | in  | load distance, load tour position, or run
//  out_ch   | out | one city with its route, or one infeasible item
//  cfg      | in  | write num_routes (index 0) or num_cities (index 1)
//
// Loads are taken one per cycle. A run gathers the tour's edge lengths
// through the one read port of the distance memory, then runs the DP with
// a read and a compare state per cut candidate (limited by the registered
// read of the best-value memory), a read and a capture state per route for
// the traceback, and one emitted city per cycle while out_ch is ready.
// Input is not taken during a run; out_ch stalls hold the output register
// and the sequencer. Reset clears control state only; stores keep data.
module minmax_route_split_dp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata,
    mmrs_in_if.sink     in_ch,
    mmrs_out_if.source  out_ch
);
    import mmrs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mmrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_func   (in_ch.func),
        .stat      (stat),
        .cmd       (cmd)
    );

    mmrs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .ld_row         (in_ch.row),
        .ld_col         (in_ch.col),
        .ld_value       (in_ch.value),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .out_route      (out_ch.route),
        .out_city       (out_ch.city),
        .out_max_length (out_ch.max_length),
        .out_infeasible (out_ch.infeasible),
        .out_last       (out_ch.last)
    );

endmodule

// ----- bench/tb.sv -----
// Testbench for the min-max route split block: loads distance tables and
// tours, runs splits, and checks every emitted city against a local model.
// Depends on mmrs_pkg, mmrs_if and the minmax_route_split_dp RTL.
module tb;
    import mmrs_pkg::*;

    localparam logic CFG_ROUTES = 1'b0;
    localparam logic CFG_CITIES = 1'b1;
    localparam int   IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [15:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  route;
        logic [4:0]  city;
        logic [20:0] max_length;
        logic        infeasible;
        logic        last;
    } city_item_t;

    // One directed row: a command plus, optionally, a typed-in result
    typedef struct {
        cmd_item_t  cmd;
        logic       has_fixed;
        city_item_t fixed;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [4:0] cfg_wdata;

    mmrs_in_if  in_ch ();
    mmrs_out_if out_ch ();

    minmax_route_split_dp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Local copy of the block's stores and registers
    logic [15:0] dist_mem [0:31][0:31];
    logic [4:0]  tour_mem [0:30];
    int unsigned routes_k;
    int unsigned cities_n;

    city_item_t  split_expect [$];
    int          mismatch_count;
    int          result_count;
    int          run_count;
    int          idle_cycles;
    bit          out_stall_en;
    bit          hold_off_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] edge_len(int unsigned a, int unsigned b);
        if (a > MAX_CITIES || b > MAX_CITIES)
            return 0;
        return dist_mem[a][b];
    endfunction

    function automatic logic [31:0] route_cost(int unsigned j, int unsigned i);
        logic [31:0] c;
        c = edge_len(0, tour_mem[j]);
        for (int unsigned x = j + 1; x < i; x++)
            c += edge_len(tour_mem[x - 1], tour_mem[x]);
        c += edge_len(tour_mem[i - 1], 0);
        return c;
    endfunction

    // Min-max split by dynamic program; queue the expected cities
    task automatic predict_split();
        logic [31:0] bval [0:31][0:8];
        bit          bok  [0:31][0:8];
        int unsigned bcut [0:31][0:8];
        int unsigned start [0:8];
        int unsigned n;
        int unsigned i;
        logic [31:0] c;
        logic [31:0] m;
        city_item_t  e;
        n = (cities_n > MAX_CITIES) ? MAX_CITIES : cities_n;
        if (routes_k == 0 || routes_k > MAX_ROUTES || n < routes_k)
        begin
            e = '0;
            e.infeasible = 1'b1;
            e.last = 1'b1;
            split_expect = {split_expect, e};
            return;
        end
        foreach (bok[a, b])
            bok[a][b] = 1'b0;
        bval[0][0] = 0;
        bok[0][0] = 1'b1;
        for (int unsigned k = 1; k <= routes_k; k++)
            for (int unsigned ii = 1; ii <= n; ii++)
                for (int unsigned j = 0; j < ii; j++)
                begin
                    if (!bok[j][k - 1])
                        continue;
                    c = route_cost(j, ii);
                    m = (bval[j][k - 1] > c) ? bval[j][k - 1] : c;
                    if (!bok[ii][k] || m < bval[ii][k])
                    begin
                        bval[ii][k] = m;
                        bok[ii][k] = 1'b1;
                        bcut[ii][k] = j;
                    end
                end
        i = n;
        for (int unsigned k = routes_k; k > 0; k--)
        begin
            start[k - 1] = bcut[i][k];
            i = start[k - 1];
        end
        start[routes_k] = n;
        for (int unsigned r = 0; r < routes_k; r++)
            for (int unsigned p = start[r]; p < start[r + 1]; p++)
            begin
                e = '0;
                e.route = r[2:0];
                e.city = tour_mem[p];
                if (p + 1 == n)
                begin
                    e.max_length = bval[n][routes_k][20:0];
                    e.last = 1'b1;
                end
                split_expect = {split_expect, e};
            end
    endtask

    // Apply one accepted command to the local model
    task automatic model_command(cmd_item_t t);
        case (t.func)
            FUNC_LOAD_DIST: dist_mem[t.row][t.col] = t.value;
            FUNC_LOAD_TOUR:
                if (t.row < MAX_CITIES)
                    tour_mem[t.row] = t.value[4:0];
            FUNC_RUN:
            begin
                run_count++;
                predict_split();
            end
            default: ;
        endcase
    endtask

    // Offer one command, sometimes with a random idle burst in front of it
    task automatic send_cmd(cmd_item_t t, bit allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= t.func;
        in_ch.row   <= t.row;
        in_ch.col   <= t.col;
        in_ch.value <= t.value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        model_command(t);
        @(negedge clk);
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (split_expect.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_ROUTES)
            routes_k = data[3:0];
        else
            cities_n = data;
    endtask

    function automatic cmd_item_t make_cmd(logic [1:0] f, int r, int c, int v);
        cmd_item_t t;
        t.func = f;
        t.row = r[4:0];
        t.col = c[4:0];
        t.value = v[15:0];
        return t;
    endfunction

    // Load a random table over nodes 0..n and a random tour of n cities
    task automatic load_problem(int unsigned n, int unsigned vmax, bit gaps);
        for (int unsigned a = 0; a <= n; a++)
            for (int unsigned b = 0; b <= n; b++)
                send_cmd(make_cmd(FUNC_LOAD_DIST, a, b, $urandom_range(0, vmax)), gaps);
        for (int unsigned p = 0; p < n; p++)
            send_cmd(make_cmd(FUNC_LOAD_TOUR, p, 0, $urandom_range(1, n)), gaps);
    endtask

    // Fill all 31 tour positions from cities 1..3; load only the edges used
    task automatic load_long_tour();
        for (int unsigned a = 0; a <= 3; a++)
            for (int unsigned b = 0; b <= 3; b++)
                if (a != 0 || b != 0)
                    send_cmd(make_cmd(FUNC_LOAD_DIST, a, b, $urandom_range(0, 65535)),
                             1'b0);
        for (int unsigned p = 0; p < MAX_CITIES; p++)
            send_cmd(make_cmd(FUNC_LOAD_TOUR, p, 0, $urandom_range(1, 3)), 1'b0);
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        city_item_t got;
        city_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.route, out_ch.city, out_ch.max_length,
                   out_ch.infeasible, out_ch.last};
            result_count++;
            if (split_expect.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result route=%0d city=%0d", got.route, got.city);
            end
            else
            begin
                want = split_expect.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display(
                            "exp r=%0d c=%0d m=%0d i=%b l=%b got r=%0d c=%0d m=%0d i=%b l=%b",
                            want.route, want.city, want.max_length, want.infeasible,
                            want.last, got.route, got.city, got.max_length,
                            got.infeasible, got.last);
                end
            end
        end
    end

    // Drive output ready: random stall bursts, or a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (out_stall_en && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        step_row_t   steps [$];
        step_row_t   s;
        city_item_t  e;
        int unsigned n;
        int unsigned k;
        int          sent;
        bit          gaps;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.row = '0;
        in_ch.col = '0;
        in_ch.value = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROUTES;
        cfg_wdata = '0;
        rst_n = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        run_count = 0;
        idle_cycles = 0;
        out_stall_en = 1'b1;
        hold_off_req = 1'b0;
        routes_k = 1;
        cities_n = 1;
        foreach (dist_mem[a, b])
            dist_mem[a][b] = '0;
        foreach (tour_mem[a])
            tour_mem[a] = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: extremes, ignored loads, no-op, a single-route run
        s.has_fixed = 1'b0;
        s.fixed = '0;
        s.cmd = make_cmd(FUNC_LOAD_DIST, 0, 1, 16'hFFFF); steps = {steps, s};
        s.cmd = make_cmd(FUNC_LOAD_DIST, 1, 0, 16'hFFFF); steps = {steps, s};
        s.cmd = make_cmd(FUNC_LOAD_TOUR, 0, 0, 16'hFFE1); steps = {steps, s};
        s.cmd = make_cmd(FUNC_LOAD_TOUR, 31, 0, 7); steps = {steps, s};
        s.cmd = make_cmd(FUNC_NOP, 31, 31, 16'hFFFF); steps = {steps, s};
        // K=1, n=1 after reset: max length 2*65535
        s.cmd = make_cmd(FUNC_RUN, 0, 0, 0);
        s.has_fixed = 1'b1;
        s.fixed = '0;
        s.fixed.city = 5'd1;
        s.fixed.max_length = 21'd131070;
        s.fixed.last = 1'b1;
        steps = {steps, s};
        s.has_fixed = 1'b0;
        s.cmd = make_cmd(FUNC_LOAD_DIST, 31, 31, 16'h5A5A); steps = {steps, s};
        s.cmd = make_cmd(FUNC_LOAD_DIST, 0, 31, 0); steps = {steps, s};
        s.cmd = make_cmd(FUNC_LOAD_DIST, 31, 0, 16'hA5A5); steps = {steps, s};
        s.cmd = make_cmd(FUNC_LOAD_TOUR, 30, 0, 31); steps = {steps, s};
        foreach (steps[x])
        begin
            if (steps[x].has_fixed)
            begin
                send_cmd(steps[x].cmd, 1'b0);
                split_expect[split_expect.size() - 1] = steps[x].fixed;
            end
            else
                send_cmd(steps[x].cmd, 1'b1);
        end
        wait_drained();

        // Infeasible settings: n < K, K = 0, K above the maximum
        write_reg(CFG_ROUTES, 5'd8);
        send_cmd(make_cmd(FUNC_RUN, 0, 0, 0), 1'b0);
        wait_drained();
        write_reg(CFG_ROUTES, 5'd0);
        send_cmd(make_cmd(FUNC_RUN, 0, 0, 0), 1'b0);
        wait_drained();
        write_reg(CFG_ROUTES, 5'd15);
        write_reg(CFG_CITIES, 5'd31);
        e = '0;
        e.infeasible = 1'b1;
        e.last = 1'b1;
        send_cmd(make_cmd(FUNC_RUN, 0, 0, 0), 1'b0);
        if (split_expect[split_expect.size() - 1] !== e)
            mismatch_count++;
        wait_drained();

        // Full-size run: 31 positions, 8 routes
        write_reg(CFG_ROUTES, 5'd8);
        load_long_tour();
        send_cmd(make_cmd(FUNC_RUN, 0, 0, 0), 1'b0);
        wait_drained();

        // Long receiver hold-off while a second run is offered behind the first
        write_reg(CFG_CITIES, 5'd3);
        write_reg(CFG_ROUTES, 5'd2);
        load_problem(3, 65535, 1'b1);
        hold_off_req = 1'b1;
        send_cmd(make_cmd(FUNC_RUN, 0, 0, 0), 1'b0);
        send_cmd(make_cmd(FUNC_RUN, 0, 0, 0), 1'b0);
        wait_drained();

        // Random phases: small problems, random settings
        sent = 0;
        while (sent < 100)
        begin
            n = $urandom_range(1, 5);
            k = $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0)
                k = $urandom_range(0, 15);
            write_reg(CFG_CITIES, n[4:0]);
            write_reg(CFG_ROUTES, k[4:0]);
            gaps = (sent <= 75);
            if (!gaps)
                out_stall_en = 1'b0;
            load_problem(n, ($urandom_range(0, 1) != 0) ? 65535 : 15, gaps);
            sent += (n + 1) * (n + 1) + n;
            for (int rr = $urandom_range(1, 2); rr > 0; rr--)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    send_cmd(make_cmd(FUNC_NOP, $urandom, $urandom, $urandom), gaps);
                    send_cmd(make_cmd(FUNC_LOAD_DIST, 0, n, $urandom), gaps);
                    sent += 2;
                end
                send_cmd(make_cmd(FUNC_RUN, $urandom, $urandom, $urandom), gaps);
                sent++;
            end
            // Sender waits here for every expected city before reconfiguring
            wait_drained();
        end
        idle_input();
        wait_drained();

        $display("Ran %0d splits (feasible, infeasible, full-size, held-off output);",
            run_count);
        $display("%0d results checked against the local model.", result_count);
        if (mismatch_count == 0 && split_expect.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
